[src/skl_pkg.sv]
// ----------------------------------------------------------------------------
// skl_pkg : shared definitions for the sorted key list engine
// Command and status codes, cell control struct and controller states.
// ----------------------------------------------------------------------------
package skl_pkg;

  // Key width is fixed by the command interface
  localparam int KEY_W = 32;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF = 16;
  localparam int TAG_W_DEF = 32;

  // Command codes
  localparam logic [2:0] CMD_APPEND   = 3'd0;
  localparam logic [2:0] CMD_PREPEND  = 3'd1;
  localparam logic [2:0] CMD_POP_HEAD = 3'd2;
  localparam logic [2:0] CMD_SORTED   = 3'd3;
  localparam logic [2:0] CMD_REMOVE   = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } skl_status_t;

  // Operation broadcast along the row of cells
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_PREPEND,
    OP_SORTED,
    OP_POP,
    OP_REMOVE
  } skl_op_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } skl_state_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic                    en;
    skl_op_t                 op;
    logic signed [KEY_W-1:0] key;
  } skl_ctrl_t;

endpackage

[src/skl_cell.sv]
// ----------------------------------------------------------------------------
// skl_cell : one slot of the ordered list
// Holds one key and tag, decides locally whether it is the slot that a
// command addresses, and shifts towards the tail or the head as told.
// ----------------------------------------------------------------------------
module skl_cell #(
  parameter int TAG_W = 32,
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  skl_pkg::skl_ctrl_t               ctrl,
  input  logic [CNT_W-1:0]                 fill,
  input  logic signed [skl_pkg::KEY_W-1:0] new_key,
  input  logic [TAG_W-1:0]                 new_tag,
  input  logic signed [skl_pkg::KEY_W-1:0] left_key,
  input  logic [TAG_W-1:0]                 left_tag,
  input  logic signed [skl_pkg::KEY_W-1:0] right_key,
  input  logic [TAG_W-1:0]                 right_tag,
  input  logic                             seen_in,
  output logic                             seen_out,
  output logic                             here,
  output logic                             tail,
  output logic signed [skl_pkg::KEY_W-1:0] key,
  output logic [TAG_W-1:0]                 tag
);
  import skl_pkg::*;

  localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

  logic cand;
  logic is_head;

  assign is_head = (IDX == '0);

  // Does this slot qualify as the addressed position?
  always_comb begin
    case (ctrl.op)
      OP_APPEND:  cand = (IDX == fill);
      OP_PREPEND: cand = is_head;
      OP_SORTED: begin
        if (is_head) begin
          cand = (fill == '0) || (key > ctrl.key);
        end else begin
          cand = (IDX >= fill) || (key >= ctrl.key);
        end
      end
      OP_POP:     cand = is_head && (fill != '0);
      OP_REMOVE:  cand = (IDX < fill) && (key == ctrl.key);
      default:    cand = 1'b0;
    endcase
  end

  // First qualifying slot wins; the flag ripples down the row
  assign here     = cand && !seen_in;
  assign seen_out = seen_in || cand;
  assign tail     = (IDX_NEXT == fill);

  // Slot update
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.op)
        OP_APPEND, OP_PREPEND, OP_SORTED: begin
          if (here) begin
            key <= new_key;
            tag <= new_tag;
          end else if (seen_in) begin
            key <= left_key;
            tag <= left_tag;
          end
        end
        OP_POP, OP_REMOVE: begin
          if (here || seen_in) begin
            key <= right_key;
            tag <= right_tag;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/sorted_key_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_key_list_engine : bounded ordered list of signed keys with tags
// Command front end and controller over a row of list cells.
// ----------------------------------------------------------------------------
// Every command is first registered; then the whole row of cells compares
// against the key, finds the addressed slot and shifts in a single step. busy
// is high only during that execute step; the result appears with done in the
// following cycle, during which the next command may already be started. The
// receiver cannot hold results off, so done must be sampled in the cycle it is
// high. Slot contents need no clearing after reset: only slots below the entry
// count are ever read. The longest path is the first-match flag rippling
// through all DEPTH cells.
module sorted_key_list_engine #(
  parameter int DEPTH     = skl_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = skl_pkg::TAG_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       command,
  input  logic [31:0]                      item_tag,
  input  logic signed [skl_pkg::KEY_W-1:0] key_in,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [31:0]                      item_out,
  output logic signed [skl_pkg::KEY_W-1:0] key_out,
  output logic                             is_empty,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count
);
  import skl_pkg::*;

  localparam int               CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_ONE = KEY_W'(1);

  // Controller
  skl_state_t state, state_next;
  logic       accept;
  logic       exec;

  // Registered command
  logic [2:0]              cmd_r;
  logic [TAG_WIDTH-1:0]    tag_r;
  logic signed [KEY_W-1:0] key_r;
  logic [TAG_WIDTH+31:0]   tag_wide;

  // List state
  logic [CNT_W-1:0] fill, fill_next;

  // Row of cells
  skl_ctrl_t               ctrl;
  skl_op_t                 op;
  logic signed [KEY_W-1:0] new_key;
  logic signed [KEY_W-1:0] cell_key [DEPTH];
  logic [TAG_WIDTH-1:0]    cell_tag [DEPTH];
  logic [DEPTH-1:0]        cell_here;
  logic [DEPTH-1:0]        cell_tail;
  logic [DEPTH:0]          seen;
  logic                    hit;
  logic                    full;

  // Selections out of the row
  logic signed [KEY_W-1:0] sel_key;
  logic [TAG_WIDTH-1:0]    sel_tag;
  logic signed [KEY_W-1:0] tail_key;
  logic [TAG_WIDTH+31:0]   sel_tag_wide;

  // Result next values
  skl_status_t             status_next;
  logic [31:0]             item_next;
  logic signed [KEY_W-1:0] kout_next;

  function automatic logic signed [KEY_W-1:0] sat_inc(input logic signed [KEY_W-1:0] k);
    sat_inc = (k == KEY_MAX) ? k : k + KEY_ONE;
  endfunction

  function automatic logic signed [KEY_W-1:0] sat_dec(input logic signed [KEY_W-1:0] k);
    sat_dec = (k == KEY_MIN) ? k : k - KEY_ONE;
  endfunction

  // Next-state logic
  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    case (state)
      S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      fill  <= '0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (exec) begin
        fill <= fill_next;
      end
    end
  end

  // Command capture, tag resized to the stored width
  assign tag_wide = {{TAG_WIDTH{1'b0}}, item_tag};

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      tag_r <= tag_wide[TAG_WIDTH-1:0];
      key_r <= key_in;
    end
  end

  // Operation for the row; inserts into a full list do nothing
  assign full = (fill == FULL_C);

  always_comb begin
    case (cmd_r)
      CMD_APPEND:   op = full ? OP_NONE : OP_APPEND;
      CMD_PREPEND:  op = full ? OP_NONE : OP_PREPEND;
      CMD_SORTED:   op = full ? OP_NONE : OP_SORTED;
      CMD_POP_HEAD: op = OP_POP;
      CMD_REMOVE:   op = OP_REMOVE;
      default:      op = OP_NONE;
    endcase
  end

  assign ctrl.en  = exec;
  assign ctrl.op  = op;
  assign ctrl.key = key_r;

  // Key for a new entry
  always_comb begin
    case (op)
      OP_APPEND:  new_key = (fill == '0) ? '0 : sat_inc(tail_key);
      OP_PREPEND: new_key = (fill == '0) ? '0 : sat_dec(cell_key[0]);
      default:    new_key = key_r;
    endcase
  end

  // Row of cells
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] lk, rk;
    logic [TAG_WIDTH-1:0]    lt, rt;

    if (i == 0) begin : g_head
      assign lk = cell_key[i];
      assign lt = cell_tag[i];
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lt = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rk = cell_key[i];
      assign rt = cell_tag[i];
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rt = cell_tag[i+1];
    end

    skl_cell #(
      .TAG_W (TAG_WIDTH),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .fill      (fill),
      .new_key   (new_key),
      .new_tag   (tag_r),
      .left_key  (lk),
      .left_tag  (lt),
      .right_key (rk),
      .right_tag (rt),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .here      (cell_here[i]),
      .tail      (cell_tail[i]),
      .key       (cell_key[i]),
      .tag       (cell_tag[i])
    );
  end

  assign hit = seen[DEPTH];

  // One-hot selection of the addressed slot and of the tail slot
  always_comb begin
    sel_key  = '0;
    sel_tag  = '0;
    tail_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_key  = sel_key  | (cell_key[i] & {KEY_W{cell_here[i]}});
      sel_tag  = sel_tag  | (cell_tag[i] & {TAG_WIDTH{cell_here[i]}});
      tail_key = tail_key | (cell_key[i] & {KEY_W{cell_tail[i]}});
    end
  end

  assign sel_tag_wide = {32'd0, sel_tag};

  // Result and count for this command
  always_comb begin
    status_next = ST_DONE;
    item_next   = '0;
    kout_next   = '0;
    fill_next   = fill;
    case (cmd_r)
      CMD_APPEND, CMD_PREPEND, CMD_SORTED: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          kout_next = new_key;
          fill_next = fill + 1'b1;
        end
      end
      CMD_POP_HEAD, CMD_REMOVE: begin
        if (hit) begin
          item_next = sel_tag_wide[31:0];
          kout_next = sel_key;
          fill_next = fill - 1'b1;
        end else begin
          status_next = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status   <= status_next;
      item_out <= item_next;
      key_out  <= kout_next;
    end
  end

  assign entry_count = fill;
  assign is_empty    = (fill == '0);

`ifndef SYNTHESIS
  // The entry count never passes the list depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FULL_C)
    else $error("entry count beyond list depth");

  // Every update cycle is followed by a result
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    exec |=> done)
    else $error("update cycle without result");

  // A full answer leaves the list at full depth
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> entry_count == FULL_C)
    else $error("full status with free slots");

  // A successful insert grows the list by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (exec && (op == OP_APPEND || op == OP_PREPEND || op == OP_SORTED))
      |=> fill == $past(fill) + 1'b1)
    else $error("insert did not add an entry");
`endif

endmodule
